@@ sv/tct_pkg.sv @@
// Package for the task completion tracker: field widths, operation and
// error codes, sequencer states and the result type of the shared subtractor.
// No dependencies; every other file of the block imports it.
package tct_pkg;

    localparam int ID_W     = 32;
    localparam int SUB_W    = ID_W + 1;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 104;
    localparam int M_PAD_W  = M_DATA_W - (3 * ID_W + 4);

    localparam logic [1:0] MODE_ALLOC  = 2'd0;
    localparam logic [1:0] MODE_FINISH = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    localparam logic [2:0] ERR_OK          = 3'd0;
    localparam logic [2:0] ERR_FULL        = 3'd1;
    localparam logic [2:0] ERR_NOT_ALLOC   = 3'd2;
    localparam logic [2:0] ERR_NOT_PENDING = 3'd3;
    localparam logic [2:0] ERR_EXHAUSTED   = 3'd4;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ARD,
        S_ACHK,
        S_CNX,
        S_CLO,
        S_CHI,
        S_CWIN,
        S_SLOT,
        S_RD,
        S_CHK,
        S_SINIT,
        S_SRD,
        S_SCHK,
        S_OUT
    } tct_state_t;

    typedef struct packed {
        logic [SUB_W-1:0] diff;
        logic             borrow;
        logic             zero;
    } tct_sub_res_t;

endpackage

@@ sv/task_completion_tracker_core.sv @@
// Task completion tracker: hands out task ids, marks them finished and
// answers completion queries. Uses tct_pkg, tct_sub and tct_bitmap.
//
// Usage: one input beat on the s_ channel carries an operation (allocate,
// finish or query) and a task id; each accepted beat gives exactly one
// result beat on the m_ channel with the new id, the query answer, an
// error code and both marks after the operation.
// The block works on one beat at a time under a small sequencer that drives
// a single 33-bit subtractor for its ordering compares and a single-port-read bitmap.
// An allocate reads and checks the next slot; a no-op, or an allocate with the id
// space exhausted, goes straight to the result. A query or finish runs the compare
// chain and may read and check one slot; a finish may then also have to
// rescan the window for the lowest pending id (up to WINDOW slots).
// Each visited slot costs one bitmap read and one check of the read data.
// The next beat can be taken in the cycle after a result is loaded.
// After reset the bitmap is cleared one slot per cycle, and s_tready stays
// low until every slot is clear. The result sits in an output register; while the
// receiver stalls, the next beat is still taken and processed, and its
// result waits until the register is free.
module task_completion_tracker_core #(
    parameter int WINDOW = 256
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // s_tdata fields from bit 0: mode[1:0], task_id[33:2], zero padding.
    input  logic [tct_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // m_tdata fields from bit 0: new_id[31:0], is_done[32], error_code[35:33],
    // lowest_pending[67:36], highest_done[99:68], zero padding.
    output logic [tct_pkg::M_DATA_W-1:0] m_tdata
);
    import tct_pkg::*;

    localparam int SW = $clog2(WINDOW);
    localparam int CW = $clog2(WINDOW + 1);
    localparam logic [SW-1:0]    LAST_SLOT = SW'(WINDOW - 1);
    localparam logic [SUB_W-1:0] WIN_W     = SUB_W'(WINDOW);

    tct_state_t state_reg, state_next;

    logic [1:0]          mode_reg, mode_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [ID_W-1:0]     next_id_reg, next_id_next;
    logic [ID_W-1:0]     highest_reg, highest_next;
    logic [ID_W-1:0]     lowest_reg, lowest_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [SW-1:0]       next_slot_reg, next_slot_next;
    logic [SUB_W-1:0]    dist_reg, dist_next;
    logic [SW-1:0]       slot_reg, slot_next;
    logic                eq_lo_reg, eq_lo_next;
    logic [ID_W-1:0]     scan_id_reg, scan_id_next;
    logic [SW-1:0]       scan_slot_reg, scan_slot_next;
    logic [ID_W-1:0]     new_id_res_reg, new_id_res_next;
    logic                done_res_reg, done_res_next;
    logic [2:0]          err_res_reg, err_res_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [SUB_W-1:0] sub_a, sub_b;
    tct_sub_res_t     sub_res;
    logic [SUB_W-1:0] nx;
    logic [SUB_W-1:0] id_w;
    logic [SW:0]      slot_wide;

    logic          mem_we;
    logic [SW-1:0] mem_waddr;
    logic          mem_wdata;
    logic [SW-1:0] mem_raddr;
    logic          mem_rdata;

    tct_sub u_sub (
        .a   (sub_a),
        .b   (sub_b),
        .res (sub_res)
    );

    tct_bitmap #(
        .WINDOW (WINDOW),
        .SW     (SW)
    ) u_bitmap (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign nx       = {~|next_id_reg, next_id_reg};
    assign id_w     = {1'b0, id_reg};
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_id_reg   <= ID_W'(1);
            highest_reg   <= '0;
            lowest_reg    <= '0;
            count_reg     <= '0;
            next_slot_reg <= SW'(1);
            scan_slot_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            next_id_reg   <= next_id_next;
            highest_reg   <= highest_next;
            lowest_reg    <= lowest_next;
            count_reg     <= count_next;
            next_slot_reg <= next_slot_next;
            scan_slot_reg <= scan_slot_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        mode_reg       <= mode_next;
        id_reg         <= id_next;
        dist_reg       <= dist_next;
        slot_reg       <= slot_next;
        eq_lo_reg      <= eq_lo_next;
        scan_id_reg    <= scan_id_next;
        new_id_res_reg <= new_id_res_next;
        done_res_reg   <= done_res_next;
        err_res_reg    <= err_res_next;
        m_tdata_reg    <= m_tdata_next;
    end

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        id_next         = id_reg;
        next_id_next    = next_id_reg;
        highest_next    = highest_reg;
        lowest_next     = lowest_reg;
        count_next      = count_reg;
        next_slot_next  = next_slot_reg;
        dist_next       = dist_reg;
        slot_next       = slot_reg;
        eq_lo_next      = eq_lo_reg;
        scan_id_next    = scan_id_reg;
        scan_slot_next  = scan_slot_reg;
        new_id_res_next = new_id_res_reg;
        done_res_next   = done_res_reg;
        err_res_next    = err_res_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        sub_a           = '0;
        sub_b           = '0;
        slot_wide       = '0;
        mem_we          = 1'b0;
        mem_waddr       = slot_reg;
        mem_wdata       = 1'b0;
        mem_raddr       = slot_reg;

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = scan_slot_reg;
                mem_wdata = 1'b0;
                if (scan_slot_reg == LAST_SLOT) begin
                    state_next = S_IDLE;
                end else begin
                    scan_slot_next = scan_slot_reg + SW'(1);
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    mode_next       = s_tdata[1:0];
                    id_next         = s_tdata[ID_W+1:2];
                    new_id_res_next = '0;
                    done_res_next   = 1'b0;
                    err_res_next    = ERR_OK;
                    if (s_tdata[1:0] == MODE_ALLOC) begin
                        if (next_id_reg == '0) begin
                            err_res_next = ERR_EXHAUSTED;
                            state_next   = S_OUT;
                        end else begin
                            state_next = S_ARD;
                        end
                    end else if (s_tdata[1:0] inside {MODE_FINISH, MODE_QUERY}) begin
                        state_next = S_CNX;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_ARD: begin
                mem_raddr  = next_slot_reg;
                state_next = S_ACHK;
            end
            S_ACHK: begin
                if (mem_rdata) begin
                    err_res_next = ERR_FULL;
                end else begin
                    mem_we          = 1'b1;
                    mem_waddr       = next_slot_reg;
                    mem_wdata       = 1'b1;
                    count_next      = count_reg + CW'(1);
                    new_id_res_next = next_id_reg;
                    next_id_next    = next_id_reg + ID_W'(1);
                    next_slot_next  = (next_slot_reg == LAST_SLOT) ? '0
                                                                   : next_slot_reg + SW'(1);
                end
                state_next = S_OUT;
            end
            S_CNX: begin
                sub_a     = nx;
                sub_b     = id_w;
                dist_next = sub_res.diff;
                if (sub_res.borrow || sub_res.zero) begin
                    err_res_next = ERR_NOT_ALLOC;
                    state_next   = S_OUT;
                end else begin
                    state_next = S_CLO;
                end
            end
            S_CLO: begin
                sub_a      = id_w;
                sub_b      = {1'b0, lowest_reg};
                eq_lo_next = sub_res.zero;
                if (sub_res.borrow) begin
                    if (mode_reg == MODE_QUERY) begin
                        done_res_next = 1'b1;
                    end else begin
                        err_res_next = ERR_NOT_PENDING;
                    end
                    state_next = S_OUT;
                end else if (mode_reg == MODE_QUERY) begin
                    state_next = S_CHI;
                end else if (id_reg == '0) begin
                    err_res_next = ERR_NOT_PENDING;
                    state_next   = S_OUT;
                end else begin
                    state_next = S_CWIN;
                end
            end
            S_CHI: begin
                sub_a = {1'b0, highest_reg};
                sub_b = id_w;
                if (sub_res.borrow) begin
                    done_res_next = 1'b0;
                    state_next    = S_OUT;
                end else begin
                    state_next = S_CWIN;
                end
            end
            S_CWIN: begin
                sub_a = WIN_W;
                sub_b = dist_reg;
                if (sub_res.borrow || (id_reg == '0)) begin
                    if (mode_reg == MODE_QUERY) begin
                        done_res_next = 1'b1;
                    end else begin
                        err_res_next = ERR_NOT_PENDING;
                    end
                    state_next = S_OUT;
                end else begin
                    state_next = S_SLOT;
                end
            end
            S_SLOT: begin
                sub_a = SUB_W'(next_slot_reg);
                sub_b = dist_reg;
                if (sub_res.borrow) begin
                    slot_wide = sub_res.diff[SW:0] + (SW + 1)'(WINDOW);
                end else begin
                    slot_wide = sub_res.diff[SW:0];
                end
                slot_next  = slot_wide[SW-1:0];
                state_next = S_RD;
            end
            S_RD: begin
                mem_raddr  = slot_reg;
                state_next = S_CHK;
            end
            S_CHK: begin
                sub_a      = {1'b0, highest_reg};
                sub_b      = id_w;
                state_next = S_OUT;
                if (mode_reg == MODE_QUERY) begin
                    done_res_next = ~mem_rdata;
                end else if (!mem_rdata) begin
                    err_res_next = ERR_NOT_PENDING;
                end else begin
                    mem_we     = 1'b1;
                    mem_waddr  = slot_reg;
                    mem_wdata  = 1'b0;
                    count_next = count_reg - CW'(1);
                    if (sub_res.borrow) begin
                        highest_next = id_reg;
                    end
                    if (eq_lo_reg || (lowest_reg == '0)) begin
                        if (count_reg == CW'(1)) begin
                            lowest_next = '0;
                        end else begin
                            state_next = S_SINIT;
                        end
                    end
                end
            end
            S_SINIT: begin
                sub_a = nx;
                sub_b = WIN_W;
                if (!sub_res.borrow && !sub_res.zero) begin
                    scan_id_next   = sub_res.diff[ID_W-1:0];
                    scan_slot_next = next_slot_reg;
                end else begin
                    scan_id_next   = ID_W'(1);
                    scan_slot_next = SW'(1);
                end
                state_next = S_SRD;
            end
            S_SRD: begin
                mem_raddr  = scan_slot_reg;
                state_next = S_SCHK;
            end
            S_SCHK: begin
                if (mem_rdata) begin
                    lowest_next = scan_id_reg;
                    state_next  = S_OUT;
                end else begin
                    scan_id_next   = scan_id_reg + ID_W'(1);
                    scan_slot_next = (scan_slot_reg == LAST_SLOT) ? '0
                                                                  : scan_slot_reg + SW'(1);
                    state_next     = S_SRD;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{M_PAD_W{1'b0}}, highest_reg, lowest_reg,
                                     err_res_reg, done_res_reg, new_id_res_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/tct_sub.sv @@
// Shared 33-bit subtract and compare unit of the task completion tracker.
// Depends on tct_pkg for the operand width and the result type.
module tct_sub (
    input  logic [tct_pkg::SUB_W-1:0] a,
    input  logic [tct_pkg::SUB_W-1:0] b,
    output tct_pkg::tct_sub_res_t     res
);
    import tct_pkg::*;

    logic [SUB_W:0] full;

    assign full       = {1'b0, a} - {1'b0, b};
    assign res.diff   = full[SUB_W-1:0];
    assign res.borrow = full[SUB_W];
    assign res.zero   = (full == '0);

endmodule

@@ sv/tct_bitmap.sv @@
// Pending bitmap of the task completion tracker: one bit per window slot,
// one write port and one read port with registered read data.
// Depends on tct_pkg only by convention; no shared types are needed.
module tct_bitmap #(
    parameter int WINDOW = 256,
    parameter int SW     = $clog2(WINDOW)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [SW-1:0] waddr,
    input  logic          wdata,
    input  logic [SW-1:0] raddr,
    output logic          rdata
);
    import tct_pkg::*;

    logic bits_reg [WINDOW];
    logic rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            bits_reg[waddr] <= wdata;
        end
        rdata_reg <= bits_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/tct_checker.sv @@
// Port-level checker for the task completion tracker core and the bind
// that attaches it. Depends on tct_pkg and task_completion_tracker_core.
module tct_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [tct_pkg::M_DATA_W-1:0] m_tdata
);
    import tct_pkg::*;

    // A stalled result beat keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Only one input beat is worked on at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again right after an accept");

    // An error result carries no new id and no finished answer.
    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[35:33] != ERR_OK) |->
            (m_tdata[31:0] == '0) && !m_tdata[32])
        else $error("error result carries payload");

    // A new id and a finished answer never appear in the same beat.
    a_alloc_vs_query: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[32] |-> (m_tdata[31:0] == '0))
        else $error("query answer and new id in one beat");

    // Error codes stay within the defined set.
    a_err_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[35:33] == ERR_OK) || (m_tdata[35:33] == ERR_FULL) ||
            (m_tdata[35:33] == ERR_NOT_ALLOC) || (m_tdata[35:33] == ERR_NOT_PENDING) ||
            (m_tdata[35:33] == ERR_EXHAUSTED))
        else $error("undefined error code");

endmodule

bind task_completion_tracker_core tct_checker u_tct_checker (.*);
